>>> rtl/pcmo_pkg.sv
// ----------------------------------------------------------------------------
// pcmo_pkg
// shared types for the pixel color matrix overlay block
// ----------------------------------------------------------------------------
package pcmo_pkg;

    localparam int unsigned NUM_REGS = 7;
    localparam int unsigned ADDR_W   = 6;
    localparam int unsigned DATA_W   = 64;

    typedef enum logic [2:0] {
        REG_RED_ROW   = 3'd0,
        REG_GREEN_ROW = 3'd1,
        REG_BLUE_ROW  = 3'd2,
        REG_SCALES    = 3'd3,
        REG_OVL_EN    = 3'd4,
        REG_OVL_COLOR = 3'd5,
        REG_OVL_ALPHA = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [47:0] red_row;
        logic [47:0] green_row;
        logic [47:0] blue_row;
        logic [47:0] scales;
        logic        ovl_en;
        logic [23:0] ovl_color;
        logic [7:0]  ovl_alpha;
    } t_cfg;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

endpackage

>>> rtl/pcmo_regs.sv
// ----------------------------------------------------------------------------
// pcmo_regs
// apb register file holding matrix, scale and overlay settings
// ----------------------------------------------------------------------------
module pcmo_regs import pcmo_pkg::*; #(
    parameter int unsigned COEFF_FRAC_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam logic [16:0] ONE_FULL = 17'(1) << COEFF_FRAC_BITS;
    localparam logic [47:0] ONE16    = {32'd0, ONE_FULL[15:0]};

    t_cfg     r_cfg;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_row   <= ONE16;
            r_cfg.green_row <= ONE16 << 16;
            r_cfg.blue_row  <= ONE16 << 32;
            r_cfg.scales    <= ONE16 | (ONE16 << 16) | (ONE16 << 32);
            r_cfg.ovl_en    <= 1'b0;
            r_cfg.ovl_color <= 24'd0;
            r_cfg.ovl_alpha <= 8'd128;
        end else if (w_wr) begin
            case (w_idx)
                REG_RED_ROW:   r_cfg.red_row   <= pwdata[47:0];
                REG_GREEN_ROW: r_cfg.green_row <= pwdata[47:0];
                REG_BLUE_ROW:  r_cfg.blue_row  <= pwdata[47:0];
                REG_SCALES:    r_cfg.scales    <= pwdata[47:0];
                REG_OVL_EN:    r_cfg.ovl_en    <= pwdata[0];
                REG_OVL_COLOR: r_cfg.ovl_color <= pwdata[23:0];
                REG_OVL_ALPHA: r_cfg.ovl_alpha <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RED_ROW:   prdata = {16'd0, r_cfg.red_row};
            REG_GREEN_ROW: prdata = {16'd0, r_cfg.green_row};
            REG_BLUE_ROW:  prdata = {16'd0, r_cfg.blue_row};
            REG_SCALES:    prdata = {16'd0, r_cfg.scales};
            REG_OVL_EN:    prdata = {63'd0, r_cfg.ovl_en};
            REG_OVL_COLOR: prdata = {40'd0, r_cfg.ovl_color};
            REG_OVL_ALPHA: prdata = {56'd0, r_cfg.ovl_alpha};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/pcmo_matrix.sv
// ----------------------------------------------------------------------------
// pcmo_matrix
// four stage color matrix: products, row sums, scale, clamp
// ----------------------------------------------------------------------------
module pcmo_matrix import pcmo_pkg::*; #(
    parameter int unsigned COEFF_FRAC_BITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_pix i_pix,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_pix o_pix
);

    localparam int unsigned PRD_W = 25;
    localparam int unsigned SUM_W = 27;
    localparam int unsigned SCL_W = 44;
    localparam int unsigned SHIFT = 2 * COEFF_FRAC_BITS;

    logic [3:0] r_vld;
    logic [7:0] r_alpha [4];

    logic signed [PRD_W-1:0] r_prod [3][3];
    logic signed [PRD_W-1:0] n_prod [3][3];
    logic signed [SUM_W-1:0] r_sum  [3];
    logic signed [SUM_W-1:0] n_sum  [3];
    logic signed [SCL_W-1:0] r_scl  [3];
    logic signed [SCL_W-1:0] n_scl  [3];
    logic        [7:0]       r_out  [3];
    logic        [7:0]       n_out  [3];

    logic [47:0]      w_rows [3];
    logic [7:0]       w_px   [3];
    logic [SCL_W-1:0] w_sh   [3];

    assign w_rows[0] = i_cfg.red_row;
    assign w_rows[1] = i_cfg.green_row;
    assign w_rows[2] = i_cfg.blue_row;
    assign w_px[0]   = i_pix.red;
    assign w_px[1]   = i_pix.green;
    assign w_px[2]   = i_pix.blue;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[ch][k] = PRD_W'($signed(w_rows[ch][16*k +: 16]))
                              * PRD_W'($signed({1'b0, w_px[k]}));
            end
            n_sum[ch] = SUM_W'(r_prod[ch][0]) + SUM_W'(r_prod[ch][1])
                      + SUM_W'(r_prod[ch][2]);
            n_scl[ch] = SCL_W'(r_sum[ch])
                      * SCL_W'($signed({1'b0, i_cfg.scales[16*ch +: 16]}));
            w_sh[ch]  = SCL_W'(r_scl[ch]) >> SHIFT;
            if (r_scl[ch] <= 0) begin
                n_out[ch] = 8'd0;
            end else if (|w_sh[ch][SCL_W-1:8]) begin
                n_out[ch] = 8'd255;
            end else begin
                n_out[ch] = w_sh[ch][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod     <= n_prod;
            r_sum      <= n_sum;
            r_scl      <= n_scl;
            r_out      <= n_out;
            r_alpha[0] <= i_pix.alpha;
            r_alpha[1] <= r_alpha[0];
            r_alpha[2] <= r_alpha[1];
            r_alpha[3] <= r_alpha[2];
        end
    end

    assign o_valid     = r_vld[3];
    assign o_pix.red   = r_out[0];
    assign o_pix.green = r_out[1];
    assign o_pix.blue  = r_out[2];
    assign o_pix.alpha = r_alpha[3];

endmodule

>>> rtl/pcmo_blend.sv
// ----------------------------------------------------------------------------
// pcmo_blend
// two stage source-over blend of the overlay color, rounded divide by 255
// ----------------------------------------------------------------------------
module pcmo_blend import pcmo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_pix i_pix,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_pix o_pix
);

    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [16:0] t;
        t = x + (x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    logic [1:0]  r_vld;
    logic [16:0] r_acc [4];
    logic [16:0] n_acc [4];
    t_pix        r_pix;
    t_pix        r_out;
    t_pix        n_out;

    logic [7:0] w_c  [3];
    logic [7:0] w_oc [3];
    logic [7:0] w_inv;
    logic [7:0] w_oa;

    assign w_oa    = i_cfg.ovl_alpha;
    assign w_inv   = 8'd255 - w_oa;
    assign w_c[0]  = i_pix.red;
    assign w_c[1]  = i_pix.green;
    assign w_c[2]  = i_pix.blue;
    assign w_oc[0] = i_cfg.ovl_color[23:16];
    assign w_oc[1] = i_cfg.ovl_color[15:8];
    assign w_oc[2] = i_cfg.ovl_color[7:0];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_acc[ch] = 17'(w_oc[ch] * w_oa) + 17'(w_c[ch] * w_inv) + 17'd127;
        end
        n_acc[3] = 17'(i_pix.alpha * w_inv) + 17'd127;
        if (i_cfg.ovl_en) begin
            n_out.red   = div255(r_acc[0]);
            n_out.green = div255(r_acc[1]);
            n_out.blue  = div255(r_acc[2]);
            n_out.alpha = w_oa + div255(r_acc[3]);
        end else begin
            n_out = r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
            r_pix <= i_pix;
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[1];
    assign o_pix   = r_out;

endmodule

>>> rtl/pixel_color_matrix_overlay.sv
// ----------------------------------------------------------------------------
// pixel_color_matrix_overlay
// rgba recoloring through a 3x3 matrix with optional constant color overlay
// ----------------------------------------------------------------------------
// pixels enter on the s_axis stream (red, green, blue, alpha from bit 0 up)
// and leave on m_axis in the same packing, one result per request, in order.
// settings sit behind the apb port, register i at byte address 8*i; write
// them only while no pixel is in flight.
// pixels pass through six register stages: products, row sums, scale
// multiply, clamp, blend products, divide by 255 into the output register.
// one pixel per cycle is sustained while m_axis does not stall, since each
// stage holds a separate pixel.
// all stages move together; when m_axis_tready is low and the output holds
// a result, the whole pipe holds and s_axis_tready drops, nothing is lost.
// empty stages hold as well, so bubbles are not filled.
// reset clears the valid bits and loads the identity matrix, unit scales,
// overlay off, overlay alpha 128.
// ----------------------------------------------------------------------------
module pixel_color_matrix_overlay import pcmo_pkg::*; #(
    parameter int unsigned COEFF_FRAC_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;
    t_pix w_in_pix;
    t_pix w_mtx_pix;
    t_pix w_out_pix;
    logic w_mtx_vld;
    logic w_en;

    assign w_en          = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_in_pix      = t_pix'(s_axis_tdata);
    assign m_axis_tdata  = w_out_pix;

    pcmo_regs #(
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pcmo_matrix #(
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_pix   (w_in_pix),
        .i_cfg   (w_cfg),
        .o_valid (w_mtx_vld),
        .o_pix   (w_mtx_pix)
    );

    pcmo_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mtx_vld),
        .i_pix   (w_mtx_pix),
        .i_cfg   (w_cfg),
        .o_valid (m_axis_tvalid),
        .o_pix   (w_out_pix)
    );

endmodule
